[rtl/sql_statement_splitter_defines.svh]
// Assertion macros for the statement splitter checker.
// Each macro expects clk and rst_n in scope.
`ifndef SQL_STATEMENT_SPLITTER_DEFINES_SVH
`define SQL_STATEMENT_SPLITTER_DEFINES_SVH

// Same-cycle implication.
`define SSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sss_pkg.sv]
package sss_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SQUOTE = 3'd1,
        MODE_DQUOTE = 3'd2,
        MODE_BTICK  = 3'd3,
        MODE_LINEC  = 3'd4,
        MODE_BLOCKC = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] b;
        kind_t      k;
    } ent_t;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        kind_t      k0;
        logic [7:0] b1;
        logic       used;
        mode_t      mode;
        logic       seen;
    } dec_t;

    function automatic logic is_blank(logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic dec_t decide(mode_t m, logic [7:0] c, logic has_nx,
                                    logic [7:0] nx, logic seen);
        dec_t       d;
        logic [7:0] q;
        d.n    = 2'd1;
        d.b0   = c;
        d.k0   = KIND_BYTE;
        d.b1   = nx;
        d.used = 1'b0;
        d.mode = m;
        d.seen = seen | !is_blank(c);
        q      = (m == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
        case (m)
            MODE_SQUOTE, MODE_DQUOTE:
            begin
                if (c == q)
                begin
                    if (has_nx && (nx == q))
                    begin
                        d.n    = 2'd2;
                        d.used = 1'b1;
                    end
                    else
                    begin
                        d.mode = MODE_NORMAL;
                    end
                end
            end
            MODE_BTICK:
            begin
                if (c == CH_BTICK)
                    d.mode = MODE_NORMAL;
            end
            MODE_LINEC:
            begin
                if (c == CH_NL)
                    d.mode = MODE_NORMAL;
            end
            MODE_BLOCKC:
            begin
                if ((c == CH_STAR) && has_nx && (nx == CH_SLASH))
                begin
                    d.n    = 2'd2;
                    d.used = 1'b1;
                    d.mode = MODE_NORMAL;
                end
            end
            default:
            begin
                if (c == CH_SQUOTE)
                    d.mode = MODE_SQUOTE;
                else if (c == CH_DQUOTE)
                    d.mode = MODE_DQUOTE;
                else if (c == CH_BTICK)
                    d.mode = MODE_BTICK;
                else if ((c == CH_DASH) && has_nx && (nx == CH_DASH))
                    d.mode = MODE_LINEC;
                else if ((c == CH_SLASH) && has_nx && (nx == CH_STAR))
                    d.mode = MODE_BLOCKC;
                else if (c == CH_SEMI)
                begin
                    d.b0   = 8'd0;
                    d.k0   = KIND_END;
                    d.seen = 1'b0;
                end
            end
        endcase
        return d;
    endfunction

endpackage

[rtl/sql_statement_splitter.sv]
// Splits script text into statements at semicolons. A byte is held back one beat for
// lookahead, so the results of a byte appear with the next beat. Each accepted beat is decided
// in the same cycle and its zero to three results are loaded into a three-entry result
// register, which drains one result per cycle with out_stall low; a new beat is taken in the
// cycle the final pending result leaves, so beats that cause one result also flow at one per
// cycle, and each extra result of escape pairs, comment closes and end of script stalls
// the input. kind 0 carries a statement byte, 1 ends a statement, 2 drops blank trailing text;
// run_end flags the last result of a beat. After a beat with last set, state is back to reset.
module sql_statement_splitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           ch,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output sss_pkg::kind_t       kind,
    output logic                 run_end
);
    import sss_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       seen_reg, seen_next;
    ent_t       ent_reg [3];
    ent_t       res [3];
    logic [1:0] cnt_reg, idx_reg;
    logic [1:0] n;
    dec_t       d1, d2;
    logic       accept, pop, last_ent;

    always_comb
    begin
        mode_next       = mode_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        seen_next       = seen_reg;
        n               = 2'd0;
        d1              = '0;
        d2              = '0;
        for (int i = 0; i < 3; i++)
            res[i] = '0;

        if (held_valid_reg)
        begin
            d1        = decide(mode_reg, held_byte_reg, 1'b1, ch, seen_reg);
            res[0]    = '{b: d1.b0, k: d1.k0};
            res[1]    = '{b: d1.b1, k: KIND_BYTE};
            n         = d1.n;
            mode_next = d1.mode;
            seen_next = d1.seen;
            if (d1.used)
            begin
                held_valid_next = 1'b0;
                held_byte_next  = 8'd0;
            end
            else
            begin
                held_byte_next = ch;
            end
        end
        else
        begin
            held_byte_next  = ch;
            held_valid_next = 1'b1;
        end

        if (last)
        begin
            if (held_valid_next)
            begin
                d2        = decide(mode_next, held_byte_next, 1'b0, 8'd0, seen_next);
                res[n]    = '{b: d2.b0, k: d2.k0};
                n         = n + 2'd1;
                seen_next = d2.seen;
            end
            res[n]          = '{b: 8'd0, k: (seen_next ? KIND_END : KIND_DISCARD)};
            n               = n + 2'd1;
            mode_next       = MODE_NORMAL;
            held_valid_next = 1'b0;
            held_byte_next  = 8'd0;
            seen_next       = 1'b0;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign last_ent  = (idx_reg == (cnt_reg - 2'd1));
    assign pop       = out_valid && !out_stall;
    assign in_stall  = out_valid && !(last_ent && !out_stall);
    assign accept    = in_valid && !in_stall;

    assign out_byte = ent_reg[idx_reg].b;
    assign kind     = ent_reg[idx_reg].k;
    assign run_end  = last_ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            held_valid_reg <= 1'b0;
            seen_reg       <= 1'b0;
            cnt_reg        <= 2'd0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg       <= mode_next;
                held_valid_reg <= held_valid_next;
                seen_reg       <= seen_next;
                cnt_reg        <= n;
                idx_reg        <= 2'd0;
            end
            else if (pop)
            begin
                if (last_ent)
                begin
                    cnt_reg <= 2'd0;
                    idx_reg <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_byte_reg <= held_byte_next;
            for (int i = 0; i < 3; i++)
                ent_reg[i] <= res[i];
        end
    end

endmodule

[rtl/sss_checker.sv]
`include "sql_statement_splitter_defines.svh"

module sss_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input logic [7:0]     out_byte,
    input sss_pkg::kind_t kind,
    input logic           run_end
);
    import sss_pkg::*;

    `SSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_byte) && $stable(kind) && $stable(run_end),
        "result beat changed while stalled")
    `SSS_ASSERT_IMP(a_marker_zero, out_valid && (kind != KIND_BYTE), out_byte == 8'd0,
        "marker beat carries a nonzero byte")
    `SSS_ASSERT_IMP(a_discard_last, out_valid && (kind == KIND_DISCARD), run_end,
        "discard marker is not the last result of its beat")
    `SSS_ASSERT_IMP(a_stall_busy, in_stall, out_valid,
        "input stalled with no pending result")

endmodule

bind sql_statement_splitter sss_checker u_sss_checker (.*);

[tb/sv/sql_statement_splitter_test.sv]
`timescale 1ns / 100ps

module sql_statement_splitter_test;

    import sss_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int RAND_ITEMS   = 350;
    localparam int CALM_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 100;

    localparam logic [7:0] SPECIALS [12] = '{
        CH_SEMI, CH_DASH, CH_SLASH, CH_STAR, CH_BTICK, CH_NL,
        CH_SQUOTE, CH_DQUOTE, CH_TAB, CH_CR, CH_SPACE, 8'h0B
    };

    localparam logic [7:0] DIRECTED_TEXT [26] = '{
        CH_SQUOTE, CH_SQUOTE, CH_SQUOTE, CH_SQUOTE, CH_SEMI,
        CH_DQUOTE, CH_DQUOTE, CH_DQUOTE, CH_DQUOTE,
        CH_BTICK, CH_SEMI, 8'h00, CH_BTICK,
        CH_DASH, CH_DASH, CH_SEMI, CH_NL,
        CH_SLASH, CH_STAR, CH_SEMI, CH_STAR, CH_SLASH,
        CH_SEMI, CH_SEMI, CH_SPACE, CH_TAB
    };

    typedef struct packed {
        logic [7:0] c;
        logic       l;
    } beat_t;

    typedef struct packed {
        logic [7:0] b;
        kind_t      k;
        logic       e;
    } result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] ch        = 8'd0;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    kind_t      kind;
    logic       run_end;

    beat_t   stim_q[$];
    result_t split_q[$];
    beat_t   beat;
    result_t next_result;

    mode_t      scan_mode     = MODE_NORMAL;
    logic [7:0] hold_ch       = 8'd0;
    logic       hold_ok       = 1'b0;
    logic       stmt_nonblank = 1'b0;

    int   total_beats;
    int   beats_taken    = 0;
    int   results_seen   = 0;
    int   mismatch_count = 0;
    int   idle_left      = 0;
    int   stall_left     = 0;
    int   quiet_cycles   = 0;
    logic calm           = 1'b0;

    sql_statement_splitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .kind      (kind),
        .run_end   (run_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic blank_char(input logic [7:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return SPECIALS[$urandom_range(0, 11)];
            1, 2:    return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] c, input logic l);
        beat_t b;
        b.c = c;
        b.l = l;
        stim_q.push_back(b);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic emit_result(input logic [7:0] b, input kind_t k);
        result_t r;
        r.b = (k == KIND_BYTE) ? b : 8'd0;
        r.k = k;
        r.e = 1'b0;
        split_q.push_back(r);
    endtask

    task automatic emit_char(input logic [7:0] c);
        if (!blank_char(c))
            stmt_nonblank = 1'b1;
        emit_result(c, KIND_BYTE);
    endtask

    task automatic scan_char(input logic [7:0] c, input logic has_nx, input logic [7:0] nx,
                             output logic took);
        logic [7:0] q;
        took = 1'b0;
        q    = (scan_mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
        case (scan_mode)
            MODE_SQUOTE, MODE_DQUOTE:
            begin
                emit_char(c);
                if (c == q)
                begin
                    if (has_nx && (nx == q))
                    begin
                        emit_char(nx);
                        took = 1'b1;
                    end
                    else
                    begin
                        scan_mode = MODE_NORMAL;
                    end
                end
            end
            MODE_BTICK:
            begin
                emit_char(c);
                if (c == CH_BTICK)
                    scan_mode = MODE_NORMAL;
            end
            MODE_LINEC:
            begin
                emit_char(c);
                if (c == CH_NL)
                    scan_mode = MODE_NORMAL;
            end
            MODE_BLOCKC:
            begin
                emit_char(c);
                if ((c == CH_STAR) && has_nx && (nx == CH_SLASH))
                begin
                    emit_char(nx);
                    took      = 1'b1;
                    scan_mode = MODE_NORMAL;
                end
            end
            default:
            begin
                if (c == CH_SEMI)
                begin
                    emit_result(8'd0, KIND_END);
                    stmt_nonblank = 1'b0;
                end
                else
                begin
                    if (c == CH_SQUOTE)
                        scan_mode = MODE_SQUOTE;
                    else if (c == CH_DQUOTE)
                        scan_mode = MODE_DQUOTE;
                    else if (c == CH_BTICK)
                        scan_mode = MODE_BTICK;
                    else if ((c == CH_DASH) && has_nx && (nx == CH_DASH))
                        scan_mode = MODE_LINEC;
                    else if ((c == CH_SLASH) && has_nx && (nx == CH_STAR))
                        scan_mode = MODE_BLOCKC;
                    emit_char(c);
                end
            end
        endcase
    endtask

    task automatic predict_beat(input logic [7:0] c, input logic l);
        logic took;
        int   first;
        first = split_q.size();
        if (hold_ok)
        begin
            scan_char(hold_ch, 1'b1, c, took);
            if (took)
            begin
                hold_ok = 1'b0;
                hold_ch = 8'd0;
            end
            else
            begin
                hold_ch = c;
            end
        end
        else
        begin
            hold_ch = c;
            hold_ok = 1'b1;
        end
        if (l)
        begin
            // flush the held byte with no lookahead, then close the script
            if (hold_ok)
                scan_char(hold_ch, 1'b0, 8'd0, took);
            if (stmt_nonblank)
                emit_result(8'd0, KIND_END);
            else
                emit_result(8'd0, KIND_DISCARD);
            scan_mode     = MODE_NORMAL;
            hold_ch       = 8'd0;
            hold_ok       = 1'b0;
            stmt_nonblank = 1'b0;
        end
        if (split_q.size() > first)
            split_q[split_q.size() - 1].e = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            ch        <= 8'd0;
            last      <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_beat(ch, last);
                beats_taken = beats_taken + 1;
            end
            calm <= (stim_q.size() < CALM_ITEMS);
            // hold the payload while the beat is stalled
            if (!in_valid || !in_stall)
            begin
                if (idle_left > 0)
                begin
                    in_valid  <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (stim_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!calm && ($urandom_range(0, 9) == 0))
                begin
                    in_valid  <= 1'b0;
                    idle_left <= $urandom_range(0, 11);
                end
                else
                begin
                    beat = stim_q.pop_front();
                    in_valid <= 1'b1;
                    ch       <= beat.c;
                    last     <= beat.l;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (split_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d unexpected: byte %02h kind %0d",
                                              results_seen, out_byte, kind));
                end
                else
                begin
                    next_result = split_q.pop_front();
                    if (out_byte !== next_result.b)
                        report_mismatch($sformatf("result %0d out_byte %02h expected %02h",
                                                  results_seen, out_byte, next_result.b));
                    if (kind !== next_result.k)
                        report_mismatch($sformatf("result %0d kind %0d expected %0d",
                                                  results_seen, kind, next_result.k));
                    if (run_end !== next_result.e)
                        report_mismatch($sformatf("result %0d run_end %0b expected %0b",
                                                  results_seen, run_end, next_result.e));
                end
                results_seen = results_seen + 1;
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && ($urandom_range(0, 9) == 0))
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 11);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int         first;
        int         n;
        logic [7:0] q;

        add_byte(8'hFF, 1'b1);
        for (int i = 0; i < 26; i++)
            add_byte(DIRECTED_TEXT[i], i == 25);

        first = stim_q.size();
        while (stim_q.size() < first + RAND_ITEMS)
        begin
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        repeat ($urandom_range(1, 5))
                            add_byte(pick_byte(), 1'b0);
                    end
                    1:
                    begin
                        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                        add_byte(q, 1'b0);
                        repeat ($urandom_range(0, 4))
                        begin
                            if ($urandom_range(0, 3) == 0)
                            begin
                                add_byte(q, 1'b0);
                                add_byte(q, 1'b0);
                            end
                            else
                            begin
                                add_byte(pick_byte(), 1'b0);
                            end
                        end
                        if ($urandom_range(0, 7) != 0)
                            add_byte(q, 1'b0);
                    end
                    2:
                    begin
                        add_byte(CH_BTICK, 1'b0);
                        repeat ($urandom_range(0, 4))
                            add_byte(pick_byte(), 1'b0);
                        if ($urandom_range(0, 7) != 0)
                            add_byte(CH_BTICK, 1'b0);
                    end
                    3:
                    begin
                        add_byte(CH_DASH, 1'b0);
                        add_byte(CH_DASH, 1'b0);
                        repeat ($urandom_range(0, 4))
                            add_byte(pick_byte(), 1'b0);
                        if ($urandom_range(0, 7) != 0)
                            add_byte(CH_NL, 1'b0);
                    end
                    4:
                    begin
                        add_byte(CH_SLASH, 1'b0);
                        add_byte(CH_STAR, 1'b0);
                        repeat ($urandom_range(0, 4))
                            add_byte(pick_byte(), 1'b0);
                        if ($urandom_range(0, 7) != 0)
                        begin
                            add_byte(CH_STAR, 1'b0);
                            add_byte(CH_SLASH, 1'b0);
                        end
                    end
                    5, 6:
                    begin
                        add_byte(CH_SEMI, 1'b0);
                    end
                    7:
                    begin
                        repeat ($urandom_range(1, 3))
                        begin
                            n = $urandom_range(9, 14);
                            add_byte((n == 14) ? CH_SPACE : 8'(n), 1'b0);
                        end
                    end
                    8:
                    begin
                        add_byte(8'($urandom_range(0, 255)), 1'b0);
                    end
                    default:
                    begin
                        add_byte(SPECIALS[$urandom_range(0, 11)], 1'b0);
                    end
                endcase
            end
            stim_q[stim_q.size() - 1].l = 1'b1;
        end
        total_beats = stim_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_taken != total_beats)
            @(posedge clk);
        while (split_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sql_statement_splitter.f]
+incdir+rtl
rtl/sss_pkg.sv
rtl/sql_statement_splitter.sv
rtl/sss_checker.sv
tb/sv/sql_statement_splitter_test.sv
